/* rtl/core/rdacc_pkg.sv */
// Shared types, constants and digit decode for the radix escape digit accumulator.
`default_nettype none
package rdacc_pkg;

  // Widths fixed by the stream format
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned CHAR_W         = 21;
  localparam int unsigned CODE_W         = 32;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned RADIX_W        = 3;
  localparam int unsigned WORTH_W        = 5;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CFG_ADDR_W     = 2;
  localparam int unsigned CFG_DATA_W     = 8;
  localparam int unsigned IN_DATA_W      = 24;
  localparam int unsigned OUT_DATA_W     = 48;

  // Register reset values
  localparam logic [COUNT_W-1:0] MAX_DIGITS_RST = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_BITS_RST = 3'd4;
  localparam logic               NEED_ALL_RST   = 1'b0;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_DIGITS = 2'd0,
    CFG_RADIX_BITS = 2'd1,
    CFG_NEED_ALL   = 2'd2
  } cfg_addr_t;

  // Field status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  // Outcome of one character against the field state
  typedef struct packed {
    logic                emit;
    status_t             status;
    logic                term;
    logic [COUNT_W-1:0]  res_count;
    logic [COUNT_W-1:0]  count_nxt;
  } step_res_t;

  localparam logic [WORTH_W-1:0] WORTH_NONE = 5'd16;

  // Decode a hex digit; non-digits give WORTH_NONE
  function automatic logic [WORTH_W-1:0] digit_worth(input logic [CHAR_W-1:0] c);
    logic [WORTH_W-1:0] w;
    w = WORTH_NONE;
    if (c >= CHAR_W'(48) && c <= CHAR_W'(57)) begin
      w = WORTH_W'(c - CHAR_W'(48));
    end else if (c >= CHAR_W'(97) && c <= CHAR_W'(102)) begin
      w = WORTH_W'(c - CHAR_W'(87));
    end else if (c >= CHAR_W'(65) && c <= CHAR_W'(70)) begin
      w = WORTH_W'(c - CHAR_W'(55));
    end
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rdacc_step.sv */
// One-character step: digit decode, overflow check and shift-add of the field state.
`default_nettype none
module rdacc_step #(
  parameter int unsigned VALUE_BITS = rdacc_pkg::VALUE_BITS_DEF
) (
  input  wire logic [rdacc_pkg::CHAR_W-1:0]  char_code,
  input  wire logic                          end_of_text,
  input  wire logic [VALUE_BITS-1:0]         acc,
  input  wire logic [rdacc_pkg::COUNT_W-1:0] digits_seen,
  input  wire logic [rdacc_pkg::COUNT_W-1:0] max_digits,
  input  wire logic [rdacc_pkg::RADIX_W-1:0] radix_bits,
  input  wire logic                          need_all,
  output logic [VALUE_BITS-1:0]              acc_nxt,
  output logic [VALUE_BITS-1:0]              res_value,
  output rdacc_pkg::step_res_t               res
);
  import rdacc_pkg::*;

  logic [RADIX_W-1:0] p_eff;
  logic [WORTH_W-1:0] worth;
  logic               is_digit;
  logic [DIGIT_W-1:0] top_bits;
  logic               ovf;
  logic [VALUE_BITS-1:0] sum;
  logic [COUNT_W:0]   count_inc;
  logic [COUNT_W:0]   max_eff;
  logic               short_fld;
  status_t            end_status;

  // Clamp the radix power to 1..4
  always_comb begin
    if (radix_bits == '0) begin
      p_eff = RADIX_W'(1);
    end else if (radix_bits > RADIX_W'(DIGIT_W)) begin
      p_eff = RADIX_W'(DIGIT_W);
    end else begin
      p_eff = radix_bits;
    end
  end

  // Decode and range-check the digit
  assign worth    = digit_worth(char_code);
  assign is_digit = worth < (WORTH_W'(1) << p_eff);

  // Bits that the shift would drop
  assign top_bits = acc[VALUE_BITS-1 -: DIGIT_W];
  always_comb begin
    case (p_eff)
      RADIX_W'(1): ovf = top_bits[3];
      RADIX_W'(2): ovf = |top_bits[3:2];
      RADIX_W'(3): ovf = |top_bits[3:1];
      default:     ovf = |top_bits;
    endcase
  end

  // Shift-add the new digit
  assign sum = (acc << p_eff) + {{(VALUE_BITS-DIGIT_W){1'b0}}, worth[DIGIT_W-1:0]};

  // Count against the limit; zero means 256
  assign count_inc  = {1'b0, digits_seen} + (COUNT_W+1)'(1);
  assign max_eff    = (max_digits == '0) ? (COUNT_W+1)'(256) : {1'b0, max_digits};
  assign short_fld  = need_all && ({1'b0, digits_seen} < max_eff);
  assign end_status = short_fld ? ST_SHORT : ST_OK;

  // Pick the outcome
  always_comb begin
    acc_nxt       = '0;
    res_value     = acc;
    res.emit      = 1'b1;
    res.status    = end_status;
    res.term      = 1'b0;
    res.res_count = digits_seen;
    res.count_nxt = '0;
    if (end_of_text) begin
      res.status = end_status;
    end else if (!is_digit) begin
      res.term = 1'b1;
    end else if (ovf) begin
      res.status = ST_OVERFLOW;
    end else if (count_inc >= max_eff) begin
      res.status    = ST_OK;
      res_value     = sum;
      res.res_count = count_inc[COUNT_W-1:0];
    end else begin
      res.emit      = 1'b0;
      acc_nxt       = sum;
      res.count_nxt = count_inc[COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/radix_escape_digit_accumulator_core.sv */
// Top level of the radix escape digit accumulator: stream ports, field state, result register.
`default_nettype none
// Accumulates the characters of a numeric escape body as digits of radix
// 2^radix_bits into a VALUE_BITS-wide code point and emits one result per
// field (value, digit count, status, terminator flag). One character is taken
// every cycle while the output is not stalled. A request lands in an input
// register and is stepped against the field state from there; its result, if
// it has one, is loaded into the output register. A stalled result holds
// the input register, and a new request still enters in the cycle that the
// output is taken. The combinational shift-add/compare loop on the accumulator
// sets the rate. Write configuration only while no request is in flight.
module radix_escape_digit_accumulator_core #(
  parameter int unsigned VALUE_BITS = rdacc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rdacc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rdacc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [20:0] char_code, [23:21] zero
  input  wire logic [rdacc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [31:0] code_value, [39:32] digit_count, [41:40] status,
  // [42] terminator_consumed, [47:43] zero
  output logic [rdacc_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import rdacc_pkg::*;

  logic [COUNT_W-1:0]    max_digits_r;
  logic [RADIX_W-1:0]    radix_bits_r;
  logic                  need_all_r;
  logic [VALUE_BITS-1:0] acc_r;
  logic [COUNT_W-1:0]    digits_r;
  logic                  stg_vld_r;
  logic [CHAR_W-1:0]     stg_char_r;
  logic                  stg_eot_r;
  logic                  out_vld_r;
  logic [CODE_W-1:0]     out_value_r;
  logic [COUNT_W-1:0]    out_count_r;
  status_t               out_status_r;
  logic                  out_term_r;

  logic                  in_fire;
  logic                  out_free;
  logic                  stg_adv;
  logic [VALUE_BITS-1:0] acc_nxt;
  logic [VALUE_BITS-1:0] res_value;
  logic [CODE_W-1:0]     value_ext;
  step_res_t             res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_digits_r <= MAX_DIGITS_RST;
      radix_bits_r <= RADIX_BITS_RST;
      need_all_r   <= NEED_ALL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_DIGITS: max_digits_r <= cfg_wdata;
        CFG_RADIX_BITS: radix_bits_r <= cfg_wdata[RADIX_W-1:0];
        CFG_NEED_ALL:   need_all_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: the stage moves when the result register can take a result
  assign out_free  = !out_vld_r || out_tready;
  assign stg_adv   = stg_vld_r && out_free;
  assign in_tready = !stg_vld_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_fire) begin
      stg_vld_r <= 1'b1;
    end else if (stg_adv) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_char_r <= in_tdata[CHAR_W-1:0];
      stg_eot_r  <= in_tlast;
    end
  end

  rdacc_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .char_code   (stg_char_r),
    .end_of_text (stg_eot_r),
    .acc         (acc_r),
    .digits_seen (digits_r),
    .max_digits  (max_digits_r),
    .radix_bits  (radix_bits_r),
    .need_all    (need_all_r),
    .acc_nxt     (acc_nxt),
    .res_value   (res_value),
    .res         (res)
  );

  // Field state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      digits_r <= '0;
    end else if (stg_adv) begin
      acc_r    <= acc_nxt;
      digits_r <= res.count_nxt;
    end
  end

  // Fit the value to the 32-bit result field
  generate
    if (VALUE_BITS >= CODE_W) begin : g_trunc
      assign value_ext = res_value[CODE_W-1:0];
    end else begin : g_ext
      assign value_ext = {{(CODE_W-VALUE_BITS){1'b0}}, res_value};
    end
  endgenerate

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stg_adv && res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && res.emit) begin
      out_value_r  <= value_ext;
      out_count_r  <= res.res_count;
      out_status_r <= res.status;
      out_term_r   <= res.term;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-CODE_W-COUNT_W-STATUS_W-1){1'b0}},
                       out_term_r, out_status_r, out_count_r, out_value_r};

  // A finished field leaves a clear accumulator and count
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && res.emit |=> acc_r == '0 && digits_r == '0)
    else $error("field state not cleared after result");

  // A stalled stage holds its character until the result side frees
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && !out_free |=> stg_vld_r && $stable(stg_char_r) && $stable(stg_eot_r))
    else $error("input stage lost while stalled");

  // Overflow never comes with a consumed terminator
  a_ovf_no_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r == ST_OVERFLOW |-> !out_term_r)
    else $error("overflow result marks a terminator");

  // A terminator result only comes from a non-digit character
  a_term_src: assert property (@(posedge clk) disable iff (!rst_n)
    stg_adv && res.emit && res.term |-> !stg_eot_r)
    else $error("terminator flagged on end of text");

endmodule
`default_nettype wire
